@@ sv/spfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Small prime factor splitter package
// Shared widths, prime and reciprocal tables, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package spfs_pkg;

  // Field widths of the stream items.
  localparam int VALUE_W  = 16;
  localparam int FACTOR_W = 17;
  localparam int COUNT_W  = 5;

  // Prime scan bounds.
  localparam int NUM_PRIMES  = 5;
  localparam int PIDX_W      = 3;
  localparam int PRIME_W     = 4;
  localparam int MAX_FACTORS = 17;
  localparam int LIST_DEPTH  = MAX_FACTORS + 1;
  localparam int SCAN_LIMIT  = 4096;
  localparam int TEST_W      = 13;
  localparam int ALLOW_W     = 2;

  // Reciprocal constants: quotient = (value * recip) >> RECIP_SHIFT,
  // exact for every 17-bit value and each of the five primes.
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 21;
  localparam int PRODUCT_W   = FACTOR_W + RECIP_W;

  // Padded tdata widths.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Prime for a scan index; the index past the end reads as zero.
  function automatic logic [PRIME_W-1:0] prime_of(input logic [PIDX_W-1:0] idx);
    logic [PRIME_W-1:0] p;
    case (idx)
      3'd0:    p = 4'd2;
      3'd1:    p = 4'd3;
      3'd2:    p = 4'd5;
      3'd3:    p = 4'd7;
      3'd4:    p = 4'd11;
      default: p = 4'd0;
    endcase
    return p;
  endfunction

  // Rounded-up reciprocal of each prime scaled by 2^RECIP_SHIFT.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [PIDX_W-1:0] idx);
    logic [RECIP_W-1:0] m;
    case (idx)
      3'd0:    m = 21'd1048576;
      3'd1:    m = 21'd699051;
      3'd2:    m = 21'd419431;
      3'd3:    m = 21'd299594;
      3'd4:    m = 21'd190651;
      default: m = 21'd0;
    endcase
    return m;
  endfunction

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_TEST,
    ST_FIN,
    ST_EMIT
  } spfs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take a new count and clear the scan state
    logic quot;   // register the reciprocal quotient
    logic test;   // apply one prime test
    logic fin;    // close the scan and prepare emission
    logic emit;   // step the descending emission
  } spfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // the scan loop has ended
    logic emit_term;  // all factor items are out, terminator is next
    logic slot_free;  // output register can take an item this cycle
  } spfs_sts_t;

endpackage

@@ sv/spfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Small prime factor splitter controller
// Sequences load, the prime tests (a quotient state, then a test state), scan close and emission.
// ----------------------------------------------------------------------------
module spfs_ctrl
  import spfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  spfs_sts_t sts_i,
  output spfs_cmd_t cmd_o
);

  spfs_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_QUOT;
        end
      end
      ST_QUOT: begin
        if (sts_i.scan_done) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.quot = 1'b1;
          state_d    = ST_TEST;
        end
      end
      ST_TEST: begin
        cmd_o.test = 1'b1;
        state_d    = ST_QUOT;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.slot_free && sts_i.emit_term) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/spfs_datapath.sv @@
// ----------------------------------------------------------------------------
// Small prime factor splitter datapath
// Holds the remaining value, the per-prime factor counts, the leftover
// factor and the output register; acts on the controller's commands.
// ----------------------------------------------------------------------------
module spfs_datapath
  import spfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic [VALUE_W-1:0]  n_value_i,
  input  spfs_cmd_t           cmd_i,
  output spfs_sts_t           sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [FACTOR_W-1:0] out_factor_o,
  output logic [COUNT_W-1:0]  out_count_o,
  output logic                out_last_o
);

  // Configuration and scan registers.
  logic                 round_en_q;
  logic [FACTOR_W-1:0]  rem_q, rem_d;
  logic [PIDX_W-1:0]    pi_q, pi_d;
  logic [ALLOW_W-1:0]   allow_q, allow_d;
  logic [TEST_W-1:0]    tests_q, tests_d;
  logic [FACTOR_W-1:0]  quo_q;
  logic [COUNT_W-1:0]   cnt_q [NUM_PRIMES];
  logic [COUNT_W-1:0]   cnt_d [NUM_PRIMES];
  logic [COUNT_W-1:0]   total_q, total_d;
  logic [FACTOR_W-1:0]  lo_q, lo_d;
  logic                 lo_pend_q, lo_pend_d;
  logic [COUNT_W-1:0]   fcount_q, fcount_d;
  logic [COUNT_W-1:0]   emitted_q, emitted_d;

  // Output register.
  logic                 out_valid_q;
  logic [FACTOR_W-1:0]  out_factor_q, out_factor_d;
  logic [COUNT_W-1:0]   out_count_q;
  logic                 out_last_q, out_last_d;

  // Working signals.
  logic [PRIME_W-1:0]   prime;
  logic [PRODUCT_W-1:0] product;
  logic [FACTOR_W+PRIME_W-1:0] qp_full;
  logic [FACTOR_W-1:0]  diff;
  logic [PRIME_W-1:0]   rmd;
  logic                 pi_valid;
  logic [COUNT_W-1:0]   cur_cnt;
  logic                 cand;
  logic                 take_lo;
  logic                 slot_free;
  logic                 term;
  logic                 item_fire;
  logic                 term_fire;
  logic [COUNT_W-1:0]   total_ext;

  assign prime    = prime_of(pi_q);
  assign pi_valid = (pi_q < PIDX_W'(NUM_PRIMES));
  assign cur_cnt  = pi_valid ? cnt_q[pi_q] : '0;

  // Reciprocal quotient of the remaining value by the current prime.
  assign product = {{RECIP_W{1'b0}}, rem_q} * {{FACTOR_W{1'b0}}, recip_of(pi_q)};

  // Remainder from the registered quotient.
  assign qp_full = {{PRIME_W{1'b0}}, quo_q} * {{FACTOR_W{1'b0}}, prime};
  assign diff    = rem_q - qp_full[FACTOR_W-1:0];
  assign rmd     = diff[PRIME_W-1:0];

  // Emission selection: the leftover goes ahead of any prime not larger than it.
  assign slot_free = !out_valid_q || out_ready_i;
  assign term      = (emitted_q == fcount_q);
  assign cand      = (cur_cnt != '0);
  assign take_lo   = lo_pend_q && (!cand || (lo_q >= {{(FACTOR_W-PRIME_W){1'b0}}, prime}));
  assign item_fire = cmd_i.emit && slot_free && !term && (cand || pi_q == '0)
                     && (take_lo || cand);
  assign term_fire = cmd_i.emit && slot_free && term;

  assign total_ext = (rem_q != FACTOR_W'(1) && total_q < COUNT_W'(LIST_DEPTH))
                     ? total_q + COUNT_W'(1) : total_q;

  // Next-state logic for the scan and emission registers.
  always_comb begin
    rem_d        = rem_q;
    pi_d         = pi_q;
    allow_d      = allow_q;
    tests_d      = tests_q;
    cnt_d        = cnt_q;
    total_d      = total_q;
    lo_d         = lo_q;
    lo_pend_d    = lo_pend_q;
    fcount_d     = fcount_q;
    emitted_d    = emitted_q;
    out_factor_d = out_factor_q;
    out_last_d   = out_last_q;

    if (cmd_i.load) begin
      rem_d     = (n_value_i == '0) ? FACTOR_W'(1) : FACTOR_W'(n_value_i);
      pi_d      = '0;
      allow_d   = ALLOW_W'(2);
      tests_d   = '0;
      total_d   = '0;
      lo_pend_d = 1'b0;
      for (int i = 0; i < NUM_PRIMES; i++) begin
        cnt_d[i] = '0;
      end
    end

    // One prime test: round up, divide, or move on to the next prime.
    if (cmd_i.test) begin
      tests_d = tests_q + TEST_W'(1);
      if (allow_q != '0 && round_en_q && rmd != '0) begin
        rem_d   = rem_q + FACTOR_W'(prime - rmd);
        allow_d = allow_q - ALLOW_W'(1);
        pi_d    = '0;
      end else if (rmd == '0) begin
        rem_d = quo_q;
        if (total_q < COUNT_W'(LIST_DEPTH) && pi_valid) begin
          cnt_d[pi_q] = cnt_q[pi_q] + COUNT_W'(1);
          total_d     = total_q + COUNT_W'(1);
        end
      end else begin
        pi_d    = pi_q + PIDX_W'(1);
        allow_d = ALLOW_W'(1);
      end
    end

    // Scan close: keep a residue above one and cap the item count.
    if (cmd_i.fin) begin
      if (rem_q != FACTOR_W'(1) && total_q < COUNT_W'(LIST_DEPTH)) begin
        lo_d      = rem_q;
        lo_pend_d = 1'b1;
      end
      total_d   = total_ext;
      fcount_d  = (total_ext > COUNT_W'(MAX_FACTORS)) ? COUNT_W'(MAX_FACTORS) : total_ext;
      emitted_d = '0;
      pi_d      = PIDX_W'(NUM_PRIMES - 1);
    end

    // Emission: one factor item, a step down to a smaller prime, or the end.
    if (cmd_i.emit && slot_free) begin
      if (term) begin
        out_factor_d = '0;
        out_last_d   = 1'b1;
      end else if (item_fire) begin
        out_last_d = 1'b0;
        emitted_d  = emitted_q + COUNT_W'(1);
        if (take_lo) begin
          out_factor_d = lo_q;
          lo_pend_d    = 1'b0;
        end else begin
          out_factor_d = {{(FACTOR_W-PRIME_W){1'b0}}, prime};
          cnt_d[pi_q]  = cur_cnt - COUNT_W'(1);
        end
      end else if (pi_q != '0) begin
        pi_d = pi_q - PIDX_W'(1);
      end
    end
  end

  // Control and scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_en_q <= 1'b1;
      rem_q      <= '0;
      pi_q       <= '0;
      allow_q    <= ALLOW_W'(2);
      tests_q    <= '0;
      total_q    <= '0;
      lo_pend_q  <= 1'b0;
      fcount_q   <= '0;
      emitted_q  <= '0;
      for (int i = 0; i < NUM_PRIMES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        round_en_q <= cfg_wdata_i;
      end
      rem_q     <= rem_d;
      pi_q      <= pi_d;
      allow_q   <= allow_d;
      tests_q   <= tests_d;
      total_q   <= total_d;
      lo_pend_q <= lo_pend_d;
      fcount_q  <= fcount_d;
      emitted_q <= emitted_d;
      cnt_q     <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.quot) begin
      quo_q <= product[PRODUCT_W-1:RECIP_SHIFT];
    end
    lo_q <= lo_d;
    if (item_fire || term_fire) begin
      out_factor_q <= out_factor_d;
      out_last_q   <= out_last_d;
      out_count_q  <= fcount_q;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_fire || term_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.scan_done = (pi_q == PIDX_W'(NUM_PRIMES)) || (rem_q == FACTOR_W'(1))
                           || (tests_q == TEST_W'(SCAN_LIMIT));
  assign sts_o.emit_term = term;
  assign sts_o.slot_free = slot_free;

  assign out_valid_o  = out_valid_q;
  assign out_factor_o = out_factor_q;
  assign out_count_o  = out_count_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTHESIS
  // The reciprocal quotient must leave a remainder below the prime.
  a_rmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.test |-> (rmd < prime))
    else $error("prime test remainder out of range");

  // The factor list never holds more entries than its depth.
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= COUNT_W'(LIST_DEPTH))
    else $error("factor list overflow");

  // Emission never passes the announced factor count.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= fcount_q)
    else $error("more factor items than announced");

  // A factor item is only sent from a real prime slot.
  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_fire |-> pi_valid)
    else $error("factor item from an invalid prime slot");
`endif

endmodule

@@ sv/small_prime_factor_splitter_unit.sv @@
// ----------------------------------------------------------------------------
// Small prime factor splitter unit
// Splits a count into factors 2, 3, 5, 7, 11 and a leftover residue, with optional
// rounding, and streams them out in descending order, ending with a terminator item.
// ----------------------------------------------------------------------------
// Usage: one count is taken at a time on the slave stream; after it the block
// streams its factors largest first, each with the total factor count, and
// closes the run with an item whose factor is 0 and tlast is high. Each prime
// test is a reciprocal multiply, then remainder and update; after the scan the
// block emits the factor items, with up to four steps between primes, and then
// the terminator. The output register lets the next count be accepted while
// the terminator still waits. round_up_enable resets to 1 and is written
// through cfg_we_i / cfg_wdata_i; the user must write it only while the block
// is idle, as the block itself does not enforce this.
module small_prime_factor_splitter_unit
  import spfs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration: round_up_enable.
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] n_value
  // Output stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [16:0] factor, [21:17] factor_count
  output logic                   m_axis_tlast
);

  spfs_cmd_t           cmd;
  spfs_sts_t           sts;
  logic [FACTOR_W-1:0] factor;
  logic [COUNT_W-1:0]  factor_count;

  // Sequencer.
  spfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Scan and emission datapath.
  spfs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .n_value_i    (s_axis_tdata[VALUE_W-1:0]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_factor_o (factor),
    .out_count_o  (factor_count),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the result fields, zero filled to whole bytes.
  assign m_axis_tdata = {{(OUT_TDATA_W-FACTOR_W-COUNT_W){1'b0}}, factor_count, factor};

endmodule

@@ tb/small_prime_factor_splitter_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Small prime factor splitter unit testbench
// Streams counts into the splitter under both rounding settings, predicts
// the descending factor list of every accepted count and checks each output
// transfer against it, with random gaps on the input and random back
// pressure on the output.
// ----------------------------------------------------------------------------
module small_prime_factor_splitter_unit_test
  import spfs_pkg::*;
();

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_REPORTS   = 10;

  // One output item as the stream carries it.
  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } factor_item_t;

  localparam int unsigned SCAN_PRIMES[NUM_PRIMES] = '{2, 3, 5, 7, 11};
  localparam int unsigned MIX_PRIMES[6] = '{2, 3, 5, 7, 11, 13};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  // Stimulus and scoreboard state.
  logic [VALUE_W-1:0] pending_counts[$];
  factor_item_t expected_factors[$];
  logic round_en = 1'b1;
  int counts_queued = 0;
  int counts_taken = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  bit in_taken = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int in_wait = 0;
  int out_hold = 0;

  small_prime_factor_splitter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Scan one count, sort the factors largest first and queue the items.
  task automatic split_into_factors(input logic [VALUE_W-1:0] n_in);
    longint unsigned rem;
    longint unsigned p;
    longint unsigned r;
    longint unsigned v;
    longint unsigned found[MAX_FACTORS + 1];
    int pidx;
    int allow;
    int tests;
    int cnt;
    int i;
    int k;
    factor_item_t item;
    rem = 64'(n_in);
    if (rem == 0) begin
      rem = 1;
    end
    pidx = 0;
    allow = 2;
    tests = 0;
    cnt = 0;
    while (pidx < NUM_PRIMES && rem != 1 && tests < SCAN_LIMIT) begin
      p = 64'(SCAN_PRIMES[pidx]);
      r = rem % p;
      tests++;
      if (allow != 0 && round_en && r != 0) begin
        // Round up to the next multiple and restart the scan at 2.
        rem += p - r;
        allow--;
        pidx = 0;
      end else if (r == 0) begin
        rem /= p;
        if (cnt < MAX_FACTORS + 1) begin
          found[cnt] = p;
          cnt++;
        end
      end else begin
        pidx++;
        allow = 1;
      end
    end
    // A residue above 1 stays as one extra factor.
    if (rem != 1 && cnt < MAX_FACTORS + 1) begin
      found[cnt] = rem;
      cnt++;
    end
    for (i = 1; i < cnt; i++) begin
      v = found[i];
      k = i;
      while (k > 0 && found[k - 1] < v) begin
        found[k] = found[k - 1];
        k--;
      end
      found[k] = v;
    end
    if (cnt > MAX_FACTORS) begin
      cnt = MAX_FACTORS;
    end
    for (i = 0; i < cnt; i++) begin
      item.factor = found[i][FACTOR_W-1:0];
      item.count = cnt[COUNT_W-1:0];
      item.last = 1'b0;
      expected_factors.push_back(item);
    end
    item.factor = '0;
    item.count = cnt[COUNT_W-1:0];
    item.last = 1'b1;
    expected_factors.push_back(item);
  endtask

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(99);
    if (calm || roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Random count: smooth numbers, plus uniform, small, near powers of two and edge values.
  function automatic logic [VALUE_W-1:0] random_count();
    int unsigned v;
    int unsigned p;
    int steps;
    logic [VALUE_W-1:0] w;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        v = 1;
        steps = $urandom_range(1, 16);
        repeat (steps) begin
          p = MIX_PRIMES[$urandom_range(0, 5)];
          if (v * p <= 65535) begin
            v = v * p;
          end
        end
        w = v[VALUE_W-1:0];
      end
      4, 5: w = 16'($urandom_range(0, 65535));
      6, 7: w = 16'($urandom_range(0, 400));
      8: begin
        w = 16'd1 << $urandom_range(1, 15);
        w = w + 16'($urandom_range(0, 4)) - 16'd2;
      end
      default: begin
        case ($urandom_range(3))
          0: w = 16'd0;
          1: w = 16'd1;
          2: w = 16'hFFFF;
          default: w = 16'($urandom_range(65000, 65535));
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic queue_count(input logic [VALUE_W-1:0] v);
    pending_counts.push_back(v);
    counts_queued++;
  endtask

  // Wait until every count is taken and every item has arrived, then settle.
  task automatic drain_and_settle();
    @(posedge clk_i);
    while (counts_taken != counts_queued || expected_factors.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write while the block is idle; the predictor follows it.
  task automatic set_rounding(input logic en);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= en;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    round_en = en;
  endtask

  task automatic queue_directed();
    queue_count(16'd0);
    queue_count(16'd1);
    queue_count(16'd2);
    queue_count(16'd11);
    queue_count(16'd13);
    queue_count(16'd1001);
    queue_count(16'd2310);
    queue_count(16'd9973);
    queue_count(16'd32768);
    queue_count(16'd49152);
    queue_count(16'd59049);
    queue_count(16'd65521);
    queue_count(16'hAAAA);
    queue_count(16'hFFFF);
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_count(random_count());
  endtask

  // Input driver: holds an item until its transfer, then maybe idles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(63) == 0) begin
        in_calm = !in_calm;
      end
      if (!s_axis_tvalid || in_taken) begin
        if (in_wait > 0) begin
          s_axis_tvalid <= 1'b0;
          in_wait--;
        end else if (pending_counts.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_counts.pop_front();
          in_wait = pick_gap(in_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  // Output back pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(63) == 0) begin
        out_calm = !out_calm;
      end
      if (out_hold > 0) begin
        m_axis_tready <= 1'b0;
        out_hold--;
      end else begin
        m_axis_tready <= 1'b1;
        out_hold = pick_gap(out_calm);
      end
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk_i) begin
    factor_item_t got;
    factor_item_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        split_into_factors(s_axis_tdata);
        counts_taken++;
        in_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.factor = m_axis_tdata[FACTOR_W-1:0];
        got.count = m_axis_tdata[FACTOR_W +: COUNT_W];
        got.last = m_axis_tlast;
        if (expected_factors.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("[%0t] unexpected item: factor %0d count %0d last %0d",
                     $realtime, got.factor, got.count, got.last);
          end
        end else begin
          want = expected_factors.pop_front();
          if (got.factor !== want.factor || got.count !== want.count ||
              got.last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("[%0t] mismatch: want factor %0d count %0d last %0d, got %0d %0d %0d",
                       $realtime, want.factor, want.count, want.last,
                       got.factor, got.count, got.last);
            end
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** small_prime_factor_splitter_unit: FAILED **");
      $finish;
    end
  end

  // Phase sequence: directed counts under both settings, then random phases.
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_rounding(1'b1);
    queue_directed();
    drain_and_settle();

    set_rounding(1'b0);
    queue_directed();
    queue_random(62);
    drain_and_settle();

    set_rounding(1'b1);
    queue_random(70);
    drain_and_settle();

    set_rounding(1'b0);
    queue_random(70);
    drain_and_settle();

    if (mismatch_cnt == 0 && expected_factors.size() == 0) begin
      $display("** small_prime_factor_splitter_unit: PASSED **");
    end else begin
      $display("** small_prime_factor_splitter_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/spfs_pkg.sv
sv/spfs_ctrl.sv
sv/spfs_datapath.sv
sv/small_prime_factor_splitter_unit.sv
tb/small_prime_factor_splitter_unit_test.sv
